/* rtl/core/i2cmra_pkg.sv */
// Shared types and constants for the I2C register-access master.
// Used by i2cmra_engine and the top level i2c_master_register_access.
package i2cmra_pkg;

    localparam int DELAY_W    = 16;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [DELAY_W-1:0] DELAY_TICKS_RESET = 16'd2;

    // register byte offsets
    localparam logic [APB_ADDR_W-1:0] ADDR_DELAY_TICKS = 3'd0;

    localparam logic [7:0] ACK_POLL_LIMIT = 8'd250;

    // one result word of the engine
    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic [7:0] rx_byte;
        logic       rx_valid;
        logic       need_byte;
        logic       busy_res;
        logic       done_res;
        logic       status;
    } res_t;

endpackage

/* rtl/core/i2cmra_engine.sv */
// Bus sequencer of the I2C register-access master: state registers plus the
// next-state and result logic for one input word. Depends on i2cmra_pkg.
module i2cmra_engine (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [i2cmra_pkg::DELAY_W-1:0] delay_ticks,
    input  logic [1:0]                    cmd,
    input  logic [6:0]                    dev_addr,
    input  logic [15:0]                   reg_addr,
    input  logic [7:0]                    byte_count,
    input  logic [7:0]                    write_byte,
    input  logic                          sda_in,
    output i2cmra_pkg::res_t              res
);

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_BYTE  = 2'd3;

    localparam logic [4:0] PH_IDLE      = 5'd0;
    localparam logic [4:0] PH_START1    = 5'd1;
    localparam logic [4:0] PH_START2    = 5'd2;
    localparam logic [4:0] PH_START3    = 5'd3;
    localparam logic [4:0] PH_TX_LOW    = 5'd4;
    localparam logic [4:0] PH_TX_HIGH   = 5'd5;
    localparam logic [4:0] PH_ACK_REL   = 5'd6;
    localparam logic [4:0] PH_ACK_HIGH  = 5'd7;
    localparam logic [4:0] PH_ACK_END   = 5'd8;
    localparam logic [4:0] PH_WAIT_BYTE = 5'd9;
    localparam logic [4:0] PH_RX_HIGH   = 5'd10;
    localparam logic [4:0] PH_RX_LOW    = 5'd11;
    localparam logic [4:0] PH_RXA1      = 5'd12;
    localparam logic [4:0] PH_RXA2      = 5'd13;
    localparam logic [4:0] PH_RXA3      = 5'd14;
    localparam logic [4:0] PH_RXA4      = 5'd15;
    localparam logic [4:0] PH_STOP1     = 5'd16;
    localparam logic [4:0] PH_STOP2     = 5'd17;
    localparam logic [4:0] PH_STOP3     = 5'd18;
    localparam logic [4:0] PH_ERR_TAIL  = 5'd19;

    localparam logic [2:0] ST_ADDR_W = 3'd0;
    localparam logic [2:0] ST_REG_HI = 3'd1;
    localparam logic [2:0] ST_REG_LO = 3'd2;
    localparam logic [2:0] ST_ADDR_R = 3'd3;
    localparam logic [2:0] ST_DATA_W = 3'd4;

    logic [4:0]                     phase_reg, phase_next;
    logic [i2cmra_pkg::DELAY_W-1:0] delay_count_reg, delay_count_next;
    logic [3:0]                     bit_index_reg, bit_index_next;
    logic [7:0]                     shift_reg, shift_next;
    logic [7:0]                     bytes_left_reg, bytes_left_next;
    logic [7:0]                     poll_count_reg, poll_count_next;
    logic [6:0]                     target_addr_reg, target_addr_next;
    logic [15:0]                    register_addr_reg, register_addr_next;
    logic                           read_mode_reg, read_mode_next;
    logic                           scl_level_reg, scl_level_next;
    logic                           sda_level_reg, sda_level_next;
    logic [2:0]                     stage_reg, stage_next;
    logic                           failed_reg, failed_next;

    logic [i2cmra_pkg::DELAY_W-1:0] dly_load;
    logic [i2cmra_pkg::DELAY_W-1:0] dc_dec;
    logic [3:0]                     bit_inc;
    logic [7:0]                     shift_tx;
    logic [7:0]                     shift_rx;
    logic [7:0]                     bytes_dec;
    logic                           arm;
    logic                           do_start;
    logic                           do_tx;
    logic [7:0]                     tx_byte;
    logic                           do_rx;
    logic                           do_stop;
    logic                           stop_err;
    logic                           got_rx;
    logic [7:0]                     rx_val;
    logic                           got_done;
    logic                           done_st;

    always_comb
    begin
        phase_next         = phase_reg;
        delay_count_next   = delay_count_reg;
        bit_index_next     = bit_index_reg;
        shift_next         = shift_reg;
        bytes_left_next    = bytes_left_reg;
        poll_count_next    = poll_count_reg;
        target_addr_next   = target_addr_reg;
        register_addr_next = register_addr_reg;
        read_mode_next     = read_mode_reg;
        scl_level_next     = scl_level_reg;
        sda_level_next     = sda_level_reg;
        stage_next         = stage_reg;
        failed_next        = failed_reg;

        dly_load  = (delay_ticks == '0) ? {{(i2cmra_pkg::DELAY_W-1){1'b0}}, 1'b1}
                                        : delay_ticks;
        dc_dec    = delay_count_reg - {{(i2cmra_pkg::DELAY_W-1){1'b0}}, 1'b1};
        bit_inc   = bit_index_reg + 4'd1;
        shift_tx  = {shift_reg[6:0], 1'b0};
        shift_rx  = {shift_reg[6:0], sda_in};
        bytes_dec = bytes_left_reg - 8'd1;

        arm      = 1'b0;
        do_start = 1'b0;
        do_tx    = 1'b0;
        tx_byte  = 8'd0;
        do_rx    = 1'b0;
        do_stop  = 1'b0;
        stop_err = 1'b0;
        got_rx   = 1'b0;
        rx_val   = 8'd0;
        got_done = 1'b0;
        done_st  = 1'b0;

        unique case (cmd)
            CMD_TICK:
            begin
                if (phase_reg != PH_IDLE && phase_reg != PH_WAIT_BYTE &&
                    delay_count_reg != '0)
                begin
                    delay_count_next = dc_dec;
                    if (dc_dec == '0)
                    begin
                        unique case (phase_reg)
                            PH_START1:
                            begin
                                sda_level_next = 1'b0;
                                phase_next     = PH_START2;
                                arm            = 1'b1;
                            end
                            PH_START2:
                            begin
                                scl_level_next = 1'b0;
                                phase_next     = PH_START3;
                                arm            = 1'b1;
                            end
                            PH_START3:
                            begin
                                do_tx   = 1'b1;
                                tx_byte = {target_addr_reg, stage_reg == ST_ADDR_R};
                            end
                            PH_TX_LOW:
                            begin
                                scl_level_next = 1'b1;
                                phase_next     = PH_TX_HIGH;
                                arm            = 1'b1;
                            end
                            PH_TX_HIGH:
                            begin
                                scl_level_next = 1'b0;
                                bit_index_next = bit_inc;
                                shift_next     = shift_tx;
                                arm            = 1'b1;
                                if (bit_inc < 4'd8)
                                begin
                                    sda_level_next = shift_tx[7];
                                    phase_next     = PH_TX_LOW;
                                end
                                else
                                begin
                                    sda_level_next = 1'b1;
                                    phase_next     = PH_ACK_REL;
                                end
                            end
                            PH_ACK_REL:
                            begin
                                scl_level_next  = 1'b1;
                                poll_count_next = 8'd0;
                                phase_next      = PH_ACK_HIGH;
                                arm             = 1'b1;
                            end
                            PH_ACK_HIGH:
                            begin
                                if (!sda_in)
                                begin
                                    scl_level_next = 1'b0;
                                    phase_next     = PH_ACK_END;
                                    arm            = 1'b1;
                                end
                                else if (poll_count_reg >= i2cmra_pkg::ACK_POLL_LIMIT)
                                begin
                                    do_stop  = 1'b1;
                                    stop_err = 1'b1;
                                end
                                else
                                begin
                                    poll_count_next = poll_count_reg + 8'd1;
                                    arm             = 1'b1;
                                end
                            end
                            PH_ACK_END:
                            begin
                                unique case (stage_reg)
                                    ST_ADDR_W:
                                    begin
                                        stage_next = ST_REG_HI;
                                        do_tx      = 1'b1;
                                        tx_byte    = register_addr_reg[15:8];
                                    end
                                    ST_REG_HI:
                                    begin
                                        stage_next = ST_REG_LO;
                                        do_tx      = 1'b1;
                                        tx_byte    = register_addr_reg[7:0];
                                    end
                                    ST_REG_LO:
                                    begin
                                        if (read_mode_reg)
                                        begin
                                            stage_next = ST_ADDR_R;
                                            do_start   = 1'b1;
                                        end
                                        else
                                        begin
                                            stage_next = ST_DATA_W;
                                            if (bytes_left_reg != 8'd0)
                                                phase_next = PH_WAIT_BYTE;
                                            else
                                                do_stop = 1'b1;
                                        end
                                    end
                                    ST_ADDR_R:
                                    begin
                                        if (bytes_left_reg != 8'd0)
                                            do_rx = 1'b1;
                                        else
                                            do_stop = 1'b1;
                                    end
                                    default:
                                    begin
                                        // data byte acked
                                        bytes_left_next = bytes_dec;
                                        if (bytes_dec != 8'd0)
                                            phase_next = PH_WAIT_BYTE;
                                        else
                                            do_stop = 1'b1;
                                    end
                                endcase
                            end
                            PH_RX_HIGH:
                            begin
                                shift_next     = shift_rx;
                                bit_index_next = bit_inc;
                                if (bit_inc >= 4'd8)
                                begin
                                    got_rx = 1'b1;
                                    rx_val = shift_rx;
                                end
                                scl_level_next = 1'b0;
                                phase_next     = PH_RX_LOW;
                                arm            = 1'b1;
                            end
                            PH_RX_LOW:
                            begin
                                arm = 1'b1;
                                if (bit_index_reg < 4'd8)
                                begin
                                    scl_level_next = 1'b1;
                                    phase_next     = PH_RX_HIGH;
                                end
                                else
                                begin
                                    // ack all but the last byte
                                    sda_level_next = !(bytes_left_reg > 8'd1);
                                    phase_next     = PH_RXA1;
                                end
                            end
                            PH_RXA1:
                            begin
                                scl_level_next = 1'b1;
                                phase_next     = PH_RXA2;
                                arm            = 1'b1;
                            end
                            PH_RXA2:
                            begin
                                scl_level_next = 1'b0;
                                phase_next     = PH_RXA3;
                                arm            = 1'b1;
                            end
                            PH_RXA3:
                            begin
                                if (bytes_left_reg > 8'd1)
                                begin
                                    sda_level_next = 1'b1;
                                    phase_next     = PH_RXA4;
                                    arm            = 1'b1;
                                end
                                else
                                begin
                                    bytes_left_next = bytes_dec;
                                    if (bytes_dec != 8'd0)
                                        do_rx = 1'b1;
                                    else
                                        do_stop = 1'b1;
                                end
                            end
                            PH_RXA4:
                            begin
                                bytes_left_next = bytes_dec;
                                if (bytes_dec != 8'd0)
                                    do_rx = 1'b1;
                                else
                                    do_stop = 1'b1;
                            end
                            PH_STOP1:
                            begin
                                scl_level_next = 1'b1;
                                phase_next     = PH_STOP2;
                                arm            = 1'b1;
                            end
                            PH_STOP2:
                            begin
                                sda_level_next = 1'b1;
                                phase_next     = PH_STOP3;
                                arm            = 1'b1;
                            end
                            PH_STOP3:
                            begin
                                if (failed_reg)
                                begin
                                    scl_level_next = 1'b0;
                                    phase_next     = PH_ERR_TAIL;
                                    arm            = 1'b1;
                                end
                                else
                                begin
                                    phase_next       = PH_IDLE;
                                    delay_count_next = '0;
                                    got_done         = 1'b1;
                                end
                            end
                            PH_ERR_TAIL:
                            begin
                                phase_next       = PH_IDLE;
                                delay_count_next = '0;
                                got_done         = 1'b1;
                                done_st          = 1'b1;
                            end
                            default:
                            begin
                                phase_next = PH_IDLE;
                            end
                        endcase
                    end
                end
            end
            CMD_BYTE:
            begin
                if (phase_reg == PH_WAIT_BYTE)
                begin
                    do_tx   = 1'b1;
                    tx_byte = write_byte;
                end
            end
            CMD_WRITE, CMD_READ:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    target_addr_next   = dev_addr;
                    register_addr_next = reg_addr;
                    bytes_left_next    = byte_count;
                    read_mode_next     = (cmd == CMD_READ);
                    poll_count_next    = 8'd0;
                    failed_next        = 1'b0;
                    stage_next         = ST_ADDR_W;
                    do_start           = 1'b1;
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase

        if (do_start)
        begin
            sda_level_next = 1'b1;
            scl_level_next = 1'b1;
            phase_next     = PH_START1;
            arm            = 1'b1;
        end
        if (do_tx)
        begin
            shift_next     = tx_byte;
            bit_index_next = 4'd0;
            sda_level_next = tx_byte[7];
            phase_next     = PH_TX_LOW;
            arm            = 1'b1;
        end
        if (do_rx)
        begin
            shift_next     = 8'd0;
            bit_index_next = 4'd0;
            sda_level_next = 1'b1;
            scl_level_next = 1'b1;
            phase_next     = PH_RX_HIGH;
            arm            = 1'b1;
        end
        if (do_stop)
        begin
            failed_next    = stop_err;
            sda_level_next = 1'b0;
            phase_next     = PH_STOP1;
            arm            = 1'b1;
        end
        if (arm)
            delay_count_next = dly_load;
    end

    always_comb
    begin
        res.scl_out   = scl_level_next;
        res.sda_out   = sda_level_next;
        res.rx_byte   = rx_val;
        res.rx_valid  = got_rx;
        res.need_byte = (phase_next == PH_WAIT_BYTE);
        res.busy_res  = (phase_next != PH_IDLE);
        res.done_res  = got_done;
        res.status    = done_st;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            delay_count_reg   <= '0;
            bit_index_reg     <= 4'd0;
            shift_reg         <= 8'd0;
            bytes_left_reg    <= 8'd0;
            poll_count_reg    <= 8'd0;
            target_addr_reg   <= 7'd0;
            register_addr_reg <= 16'd0;
            read_mode_reg     <= 1'b0;
            scl_level_reg     <= 1'b1;
            sda_level_reg     <= 1'b1;
            stage_reg         <= ST_ADDR_W;
            failed_reg        <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg         <= phase_next;
            delay_count_reg   <= delay_count_next;
            bit_index_reg     <= bit_index_next;
            shift_reg         <= shift_next;
            bytes_left_reg    <= bytes_left_next;
            poll_count_reg    <= poll_count_next;
            target_addr_reg   <= target_addr_next;
            register_addr_reg <= register_addr_next;
            read_mode_reg     <= read_mode_next;
            scl_level_reg     <= scl_level_next;
            sda_level_reg     <= sda_level_next;
            stage_reg         <= stage_next;
            failed_reg        <= failed_next;
        end
    end

`ifndef SYNTHESIS
    // only idle and byte-wait phases may sit with an empty delay counter
    a_delay_armed: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_IDLE && phase_reg != PH_WAIT_BYTE) |-> (delay_count_reg != '0))
        else $error("active phase with no delay pending");

    a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_index_reg <= 4'd8)
        else $error("bit index past eight");

    a_poll_range: assert property (@(posedge clk) disable iff (!rst_n)
        poll_count_reg <= i2cmra_pkg::ACK_POLL_LIMIT)
        else $error("ack poll count past limit");

    a_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> ($stable(phase_reg) && $stable(delay_count_reg)))
        else $error("sequencer moved without an accepted word");
`endif

endmodule

/* rtl/core/i2c_master_register_access.sv */
// Top level of the I2C register-access master: APB register, engine and
// result register. Depends on i2cmra_pkg and i2cmra_engine.

// Each input word (tick with SDA sample, begin write, begin read, next
// write byte) yields exactly one result word carrying the SCL/SDA drive
// levels and status. One word is taken every clock while the output side
// is not stalling, also while a result is pending: the sequencer step is
// a single pass of logic from the state registers into the result
// register, so each result shows in the cycle after its word. Bus timing
// is counted in tick words, delay_ticks per half bit (0 acts as 1); write
// delay_ticks at APB offset 0 only while no transaction is running.
module i2c_master_register_access (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [1:0]                       cmd,
    input  logic [6:0]                       dev_addr,
    input  logic [15:0]                      reg_addr,
    input  logic [7:0]                       byte_count,
    input  logic [7:0]                       write_byte,
    input  logic                             sda_in,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             scl_out,
    output logic                             sda_out,
    output logic [7:0]                       rx_byte,
    output logic                             rx_valid,
    output logic                             need_byte,
    output logic                             busy_res,
    output logic                             done_res,
    output logic                             status,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [i2cmra_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [i2cmra_pkg::APB_DATA_W-1:0] pwdata,
    output logic [i2cmra_pkg::APB_DATA_W-1:0] prdata,
    output logic                             pready
);

    logic [i2cmra_pkg::DELAY_W-1:0] delay_ticks_reg;
    logic                           out_valid_reg;
    i2cmra_pkg::res_t               res_reg;
    i2cmra_pkg::res_t               res_next;
    logic                           accept;
    logic                           sel_delay;

    assign pready    = 1'b1;
    // low address bits ignored: one word-aligned register
    assign sel_delay = (paddr[i2cmra_pkg::APB_ADDR_W-1] ==
                        i2cmra_pkg::ADDR_DELAY_TICKS[i2cmra_pkg::APB_ADDR_W-1]);

    always_comb
    begin
        prdata = '0;
        if (sel_delay)
            prdata = {{(i2cmra_pkg::APB_DATA_W-i2cmra_pkg::DELAY_W){1'b0}}, delay_ticks_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            delay_ticks_reg <= i2cmra_pkg::DELAY_TICKS_RESET;
        else if (psel && penable && pwrite && sel_delay)
            delay_ticks_reg <= pwdata[i2cmra_pkg::DELAY_W-1:0];
    end

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    i2cmra_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .delay_ticks (delay_ticks_reg),
        .cmd         (cmd),
        .dev_addr    (dev_addr),
        .reg_addr    (reg_addr),
        .byte_count  (byte_count),
        .write_byte  (write_byte),
        .sda_in      (sda_in),
        .res         (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            res_reg <= res_next;
    end

    assign out_valid = out_valid_reg;
    assign scl_out   = res_reg.scl_out;
    assign sda_out   = res_reg.sda_out;
    assign rx_byte   = res_reg.rx_byte;
    assign rx_valid  = res_reg.rx_valid;
    assign need_byte = res_reg.need_byte;
    assign busy_res  = res_reg.busy_res;
    assign done_res  = res_reg.done_res;
    assign status    = res_reg.status;

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && done_res) |-> (!busy_res && !need_byte))
        else $error("transaction done but still busy");

    a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status) |-> done_res)
        else $error("error status without done");

    a_rx_not_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(rx_valid && done_res))
        else $error("received byte on the finishing word");

    a_need_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && need_byte) |-> busy_res)
        else $error("byte request while idle");
`endif

endmodule

/* verif/i2cmra_tb_pkg.sv */
// Command codes of the input word, shared by the stimulus in tb_top and by
// i2cmra_checker. Depends on nothing.
package i2cmra_tb_pkg;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2,
        CMD_BYTE  = 2'd3
    } cmd_e;

endpackage

/* verif/i2cmra_checker.sv */
// Checker for the I2C register-access master: snoops the input, result and
// APB channels, predicts each result word and compares it with the block.
// Depends on i2cmra_pkg and i2cmra_tb_pkg.
module i2cmra_checker
    import i2cmra_pkg::*;
    import i2cmra_tb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [1:0]            cmd,
    input  logic [6:0]            dev_addr,
    input  logic [15:0]           reg_addr,
    input  logic [7:0]            byte_count,
    input  logic [7:0]            write_byte,
    input  logic                  sda_in,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic                  scl_out,
    input  logic                  sda_out,
    input  logic [7:0]            rx_byte,
    input  logic                  rx_valid,
    input  logic                  need_byte,
    input  logic                  busy_res,
    input  logic                  done_res,
    input  logic                  status,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic [APB_DATA_W-1:0] prdata,
    input  logic                  pready,
    output int                    errors,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [4:0] {
        PH_IDLE, PH_START1, PH_START2, PH_START3, PH_TX_LOW, PH_TX_HIGH,
        PH_ACK_REL, PH_ACK_HIGH, PH_ACK_END, PH_WAIT_BYTE, PH_RX_HIGH, PH_RX_LOW,
        PH_RXA1, PH_RXA2, PH_RXA3, PH_RXA4, PH_STOP1, PH_STOP2, PH_STOP3, PH_ERR_TAIL
    } bus_phase_e;

    typedef enum logic [2:0] {
        HDR_ADDR_W, HDR_REG_HI, HDR_REG_LO, HDR_ADDR_R, HDR_DATA
    } byte_stage_e;

    // shadow of the engine
    logic [DELAY_W-1:0] m_delay;
    bus_phase_e         m_phase;
    logic [15:0]        m_wait;
    logic [3:0]         m_bit;
    logic [7:0]         m_shift;
    logic [7:0]         m_left;
    logic [7:0]         m_polls;
    logic [6:0]         m_dev;
    logic [15:0]        m_reg;
    logic               m_read;
    logic               m_scl;
    logic               m_sda;
    byte_stage_e        m_stage;
    logic               m_fail;

    // per-word side outputs
    logic               w_rx;
    logic [7:0]         w_rx_byte;
    logic               w_done;
    logic               w_status;

    res_t predicted_words[$];
    int   n_bad;
    int   n_words;

    task arm_delay(input bus_phase_e nxt);
        m_phase = nxt;
        m_wait  = (m_delay == 0) ? 16'd1 : m_delay;
    endtask

    task send_start();
        m_sda = 1'b1;
        m_scl = 1'b1;
        arm_delay(PH_START1);
    endtask

    task shift_out(input logic [7:0] b);
        m_shift = b;
        m_bit   = 4'd0;
        m_sda   = b[7];
        arm_delay(PH_TX_LOW);
    endtask

    task shift_in();
        m_shift = 8'd0;
        m_bit   = 4'd0;
        m_sda   = 1'b1;
        m_scl   = 1'b1;
        arm_delay(PH_RX_HIGH);
    endtask

    task send_stop(input logic err);
        m_fail = err;
        m_sda  = 1'b0;
        arm_delay(PH_STOP1);
    endtask

    task close_xfer(input logic st);
        m_phase  = PH_IDLE;
        m_wait   = 16'd0;
        w_done   = 1'b1;
        w_status = st;
    endtask

    task next_data();
        if (m_left != 0)
            m_phase = PH_WAIT_BYTE;
        else
            send_stop(1'b0);
    endtask

    task end_rx_byte();
        m_left = m_left - 8'd1;
        if (m_left != 0)
            shift_in();
        else
            send_stop(1'b0);
    endtask

    // one bus sequencer step for an accepted input word
    task step_bus_master(input logic [1:0] c, input logic [6:0] dev, input logic [15:0] ra,
                         input logic [7:0] cnt, input logic [7:0] wb, input logic smp,
                         output res_t r);
        w_rx      = 1'b0;
        w_rx_byte = 8'd0;
        w_done    = 1'b0;
        w_status  = 1'b0;
        if (c == CMD_TICK)
        begin
            if (m_phase != PH_IDLE && m_phase != PH_WAIT_BYTE && m_wait != 0)
            begin
                m_wait = m_wait - 16'd1;
                if (m_wait == 0)
                begin
                    case (m_phase)
                        PH_START1:
                        begin
                            m_sda = 1'b0;
                            arm_delay(PH_START2);
                        end
                        PH_START2:
                        begin
                            m_scl = 1'b0;
                            arm_delay(PH_START3);
                        end
                        PH_START3:
                        begin
                            if (m_stage == HDR_ADDR_R)
                                shift_out({m_dev, 1'b1});
                            else
                                shift_out({m_dev, 1'b0});
                        end
                        PH_TX_LOW:
                        begin
                            m_scl = 1'b1;
                            arm_delay(PH_TX_HIGH);
                        end
                        PH_TX_HIGH:
                        begin
                            m_scl   = 1'b0;
                            m_bit   = m_bit + 4'd1;
                            m_shift = m_shift << 1;
                            if (m_bit < 8)
                            begin
                                m_sda = m_shift[7];
                                arm_delay(PH_TX_LOW);
                            end
                            else
                            begin
                                m_sda = 1'b1;
                                arm_delay(PH_ACK_REL);
                            end
                        end
                        PH_ACK_REL:
                        begin
                            m_scl   = 1'b1;
                            m_polls = 8'd0;
                            arm_delay(PH_ACK_HIGH);
                        end
                        PH_ACK_HIGH:
                        begin
                            if (!smp)
                            begin
                                m_scl = 1'b0;
                                arm_delay(PH_ACK_END);
                            end
                            else if (m_polls >= ACK_POLL_LIMIT)
                                send_stop(1'b1);
                            else
                            begin
                                m_polls = m_polls + 8'd1;
                                arm_delay(PH_ACK_HIGH);
                            end
                        end
                        PH_ACK_END:
                        begin
                            case (m_stage)
                                HDR_ADDR_W:
                                begin
                                    m_stage = HDR_REG_HI;
                                    shift_out(m_reg[15:8]);
                                end
                                HDR_REG_HI:
                                begin
                                    m_stage = HDR_REG_LO;
                                    shift_out(m_reg[7:0]);
                                end
                                HDR_REG_LO:
                                begin
                                    if (m_read)
                                    begin
                                        m_stage = HDR_ADDR_R;
                                        send_start();
                                    end
                                    else
                                    begin
                                        m_stage = HDR_DATA;
                                        next_data();
                                    end
                                end
                                HDR_ADDR_R:
                                begin
                                    if (m_left != 0)
                                        shift_in();
                                    else
                                        send_stop(1'b0);
                                end
                                default:
                                begin
                                    m_left = m_left - 8'd1;
                                    next_data();
                                end
                            endcase
                        end
                        PH_RX_HIGH:
                        begin
                            m_shift = {m_shift[6:0], smp};
                            m_bit   = m_bit + 4'd1;
                            if (m_bit >= 8)
                            begin
                                w_rx      = 1'b1;
                                w_rx_byte = m_shift;
                            end
                            m_scl = 1'b0;
                            arm_delay(PH_RX_LOW);
                        end
                        PH_RX_LOW:
                        begin
                            if (m_bit < 8)
                            begin
                                m_scl = 1'b1;
                                arm_delay(PH_RX_HIGH);
                            end
                            else
                            begin
                                // master ack on all but the last byte
                                m_sda = (m_left > 1) ? 1'b0 : 1'b1;
                                arm_delay(PH_RXA1);
                            end
                        end
                        PH_RXA1:
                        begin
                            m_scl = 1'b1;
                            arm_delay(PH_RXA2);
                        end
                        PH_RXA2:
                        begin
                            m_scl = 1'b0;
                            arm_delay(PH_RXA3);
                        end
                        PH_RXA3:
                        begin
                            if (m_left > 1)
                            begin
                                m_sda = 1'b1;
                                arm_delay(PH_RXA4);
                            end
                            else
                                end_rx_byte();
                        end
                        PH_RXA4:
                            end_rx_byte();
                        PH_STOP1:
                        begin
                            m_scl = 1'b1;
                            arm_delay(PH_STOP2);
                        end
                        PH_STOP2:
                        begin
                            m_sda = 1'b1;
                            arm_delay(PH_STOP3);
                        end
                        PH_STOP3:
                        begin
                            if (m_fail)
                            begin
                                m_scl = 1'b0;
                                arm_delay(PH_ERR_TAIL);
                            end
                            else
                                close_xfer(1'b0);
                        end
                        PH_ERR_TAIL:
                            close_xfer(1'b1);
                        default:
                            m_phase = PH_IDLE;
                    endcase
                end
            end
        end
        else if (c == CMD_BYTE)
        begin
            if (m_phase == PH_WAIT_BYTE)
                shift_out(wb);
        end
        else if (m_phase == PH_IDLE)
        begin
            m_dev   = dev;
            m_reg   = ra;
            m_left  = cnt;
            m_read  = (c == CMD_READ);
            m_polls = 8'd0;
            m_fail  = 1'b0;
            m_stage = HDR_ADDR_W;
            send_start();
        end
        r.scl_out   = m_scl;
        r.sda_out   = m_sda;
        r.rx_byte   = w_rx_byte;
        r.rx_valid  = w_rx;
        r.need_byte = (m_phase == PH_WAIT_BYTE);
        r.busy_res  = (m_phase != PH_IDLE);
        r.done_res  = w_done;
        r.status    = w_status;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t seen;
        res_t want;
        if (!rst_n)
        begin
            m_delay = DELAY_TICKS_RESET;
            m_phase = PH_IDLE;
            m_wait  = 16'd0;
            m_bit   = 4'd0;
            m_shift = 8'd0;
            m_left  = 8'd0;
            m_polls = 8'd0;
            m_dev   = 7'd0;
            m_reg   = 16'd0;
            m_read  = 1'b0;
            m_scl   = 1'b1;
            m_sda   = 1'b1;
            m_stage = HDR_ADDR_W;
            m_fail  = 1'b0;
            n_bad   = 0;
            n_words = 0;
            predicted_words.delete();
            pending <= 0;
            errors  <= 0;
        end
        else
        begin
            if (psel && penable && pready && paddr == ADDR_DELAY_TICKS)
            begin
                if (pwrite)
                    m_delay = pwdata[DELAY_W-1:0];
                else if (prdata !== {{(APB_DATA_W-DELAY_W){1'b0}}, m_delay})
                begin
                    n_bad = n_bad + 1;
                    if (n_bad <= 10)
                        $display("delay_ticks readback: exp %h got %h", m_delay, prdata);
                end
            end
            if (out_valid && !out_stall)
            begin
                seen = {scl_out, sda_out, rx_byte, rx_valid, need_byte, busy_res,
                        done_res, status};
                if (predicted_words.size() == 0)
                begin
                    n_bad = n_bad + 1;
                    if (n_bad <= 10)
                        $display("result word %0d arrived with nothing predicted", n_words);
                end
                else
                begin
                    want = predicted_words.pop_front();
                    if (seen !== want)
                    begin
                        n_bad = n_bad + 1;
                        if (n_bad <= 10)
                            $display({"word %0d: exp scl=%b sda=%b rx=%h/%b need=%b busy=%b",
                                      " done=%b st=%b | got scl=%b sda=%b rx=%h/%b need=%b",
                                      " busy=%b done=%b st=%b"}, n_words,
                                     want.scl_out, want.sda_out, want.rx_byte, want.rx_valid,
                                     want.need_byte, want.busy_res, want.done_res,
                                     want.status, seen.scl_out, seen.sda_out, seen.rx_byte,
                                     seen.rx_valid, seen.need_byte, seen.busy_res,
                                     seen.done_res, seen.status);
                    end
                end
                n_words = n_words + 1;
            end
            if (in_valid && !in_stall)
            begin
                step_bus_master(cmd, dev_addr, reg_addr, byte_count, write_byte, sda_in, want);
                predicted_words.push_back(want);
            end
            pending <= predicted_words.size();
            errors  <= n_bad;
        end
    end

endmodule

/* verif/tb_top.sv */
// Top of the I2C register-access master testbench: clock, reset, APB setup,
// bus-reactive stimulus and the verdict. Depends on i2cmra_pkg,
// i2cmra_tb_pkg, i2cmra_checker and i2c_master_register_access.
module tb_top;
    import i2cmra_pkg::*;
    import i2cmra_tb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [APB_ADDR_W-1:0] ADDR_UNMAPPED = 3'd4;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  in_valid   = 1'b0;
    logic                  in_stall;
    logic [1:0]            cmd        = CMD_TICK;
    logic [6:0]            dev_addr   = 7'd0;
    logic [15:0]           reg_addr   = 16'd0;
    logic [7:0]            byte_count = 8'd0;
    logic [7:0]            write_byte = 8'd0;
    logic                  sda_in     = 1'b0;
    logic                  out_valid;
    logic                  out_stall  = 1'b0;
    logic                  scl_out;
    logic                  sda_out;
    logic [7:0]            rx_byte;
    logic                  rx_valid;
    logic                  need_byte;
    logic                  busy_res;
    logic                  done_res;
    logic                  status;
    logic                  psel       = 1'b0;
    logic                  penable    = 1'b0;
    logic                  pwrite     = 1'b0;
    logic [APB_ADDR_W-1:0] paddr      = '0;
    logic [APB_DATA_W-1:0] pwdata     = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    int                    errors;
    int                    pending;

    int idle_pct  = 0;
    int stall_pct = 0;
    int word_idx  = 0;   // words accepted so far
    int last_idx  = 0;   // index of the word just accepted
    int res_idx   = 0;
    int need_at   = -1;  // latest result index showing need_byte
    int idle_at   = -1;  // latest result index showing not busy

    i2c_master_register_access i_dut (.*);

    i2cmra_checker i_checker (.*);

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // feedback for the stimulus; nonblocking so the sender sees last cycle's view
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            res_idx <= res_idx + 1;
            if (need_byte)
                need_at <= res_idx;
            if (!busy_res)
                idle_at <= res_idx;
        end
    end

    task automatic send_word(input cmd_e c, input logic [6:0] dev, input logic [15:0] ra,
                             input logic [7:0] cnt, input logic [7:0] wb, input logic s);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        cmd        <= c;
        dev_addr   <= dev;
        reg_addr   <= ra;
        byte_count <= cnt;
        write_byte <= wb;
        sda_in     <= s;
        do
            @(posedge clk);
        while (in_stall);
        last_idx = word_idx;
        word_idx = word_idx + 1;
    endtask

    task automatic send_tick(input logic s);
        send_word(CMD_TICK, 7'($urandom), 16'($urandom), 8'($urandom), 8'($urandom), s);
    endtask

    task automatic apb_xfer(input logic wr, input logic [APB_ADDR_W-1:0] a,
                            input logic [APB_DATA_W-1:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= a;
        pwdata  <= d;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_delay(input logic [15:0] dly);
        logic [APB_DATA_W-1:0] w;
        w       = $urandom;
        w[15:0] = dly;
        apb_xfer(1'b1, ADDR_DELAY_TICKS, w);
        apb_xfer(1'b0, ADDR_DELAY_TICKS, '0);
    endtask

    // wait until every predicted word has come back
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    // one transaction: begin, then ticks and data words until the block is idle
    task automatic run_xfer(input logic rd, input logic [6:0] dev, input logic [15:0] ra,
                            input logic [7:0] cnt, input int data_byte, input int nack_after,
                            input logic noisy);
        int         b;
        int         last_data;
        int         n;
        logic       s;
        logic [7:0] wbv;
        repeat ($urandom_range(2)) send_tick(1'($urandom_range(1)));
        send_word(rd ? CMD_READ : CMD_WRITE, dev, ra, cnt, 8'($urandom),
                  1'($urandom_range(1)));
        b         = last_idx;
        last_data = b;
        n         = 0;
        while (idle_at <= b)
        begin
            if (nack_after >= 0 && n >= nack_after)
                s = 1'b1;
            else
                s = ($urandom_range(99) < 35);
            if (data_byte < 0)
                wbv = 8'($urandom);
            else
                wbv = 8'(data_byte);
            if (need_at > last_data)
            begin
                send_word(CMD_BYTE, 7'($urandom), 16'($urandom), 8'($urandom), wbv, s);
                last_data = last_idx;
            end
            else if (noisy && word_idx <= b + 10 && $urandom_range(7) == 0)
                // begin while busy: the header is still going out
                send_word($urandom_range(1) ? CMD_READ : CMD_WRITE, 7'($urandom),
                          16'($urandom), 8'($urandom), 8'($urandom), s);
            else if (noisy && $urandom_range(39) == 0)
                send_word(CMD_BYTE, 7'($urandom), 16'($urandom), 8'($urandom),
                          8'($urandom), s);
            else
                send_tick(s);
            n = n + 1;
        end
    endtask

    initial
    begin
        int         ph;
        int         start;
        int         pick;
        int         nack;
        logic [7:0] cnt;
        logic [15:0] dly;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset delay first, then the corner transactions
        apb_xfer(1'b0, ADDR_DELAY_TICKS, '0);
        run_xfer(1'b0, 7'h7F, 16'hFFFF, 8'd1, 8'hFF, -1, 1'b0);
        drain();
        apb_xfer(1'b1, ADDR_UNMAPPED, $urandom);
        set_delay(16'd1);
        run_xfer(1'b0, 7'h00, 16'h0000, 8'd0, -1, -1, 1'b0);
        run_xfer(1'b1, 7'h55, 16'h1234, 8'd0, -1, -1, 1'b0);
        run_xfer(1'b1, 7'h7F, 16'hFFFF, 8'd3, -1, -1, 1'b1);
        run_xfer(1'b0, 7'h2A, 16'h00FF, 8'd2, 8'h00, -1, 1'b1);
        run_xfer(1'b1, 7'h3C, 16'hA5A5, 8'd2, -1, 0, 1'b0);

        for (ph = 0; ph < 4; ph++)
        begin
            drain();
            case (ph)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                    dly       = 16'd1;
                end
                1:
                begin
                    idle_pct  = 71;
                    stall_pct = 0;
                    dly       = 16'd0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 71;
                    dly       = 16'($urandom_range(2, 1));
                end
                default:
                begin
                    idle_pct  = 29;
                    stall_pct = 29;
                    dly       = 16'($urandom_range(2, 1));
                end
            endcase
            set_delay(dly);
            start = word_idx;
            while (word_idx - start < 40)
            begin
                pick = $urandom_range(99);
                if (pick < 10)
                    cnt = 8'd0;
                else if (pick < 85)
                    cnt = 8'($urandom_range(4, 1));
                else
                    cnt = 8'($urandom_range(16, 5));
                if ($urandom_range(99) < 15)
                    nack = $urandom_range(300);
                else
                    nack = -1;
                run_xfer(1'($urandom_range(1)), 7'($urandom), 16'($urandom), cnt, -1, nack,
                         $urandom_range(2) == 0);
            end
        end

        // widest delay: the start condition holds through every tick
        drain();
        idle_pct  = 0;
        stall_pct = 0;
        set_delay(16'hFFFF);
        send_word(CMD_WRITE, 7'($urandom), 16'($urandom), 8'd1, 8'($urandom), 1'b0);
        repeat (20) send_tick(1'b0);
        drain();

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* files.f */
rtl/core/i2cmra_pkg.sv
rtl/core/i2cmra_engine.sv
rtl/core/i2c_master_register_access.sv
verif/i2cmra_tb_pkg.sv
verif/i2cmra_checker.sv
verif/tb_top.sv
